### rtl/core/cpsf_pkg.sv
// ----------------------------------------------------------------------------
// cpsf_pkg
// Shared types, constants and folding functions for the code point folder.
// ----------------------------------------------------------------------------
package cpsf_pkg;

	localparam int CP_W    = 21;
	localparam int TDATA_W = 24;
	localparam int IDX_W   = 2;

	typedef logic [CP_W-1:0] cp_t;
	typedef logic [6:0]      ascii_t;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FOLD_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FOLD_LETTER = 2'd1;
	localparam logic [IDX_W-1:0] REG_FOLD_DIGIT  = 2'd2;
	localparam logic [IDX_W-1:0] REG_FOLD_CASE   = 2'd3;

	typedef struct packed {
		cp_t    cp;
		ascii_t to;
	} pair_t;

	typedef struct packed {
		cp_t    lo;
		cp_t    hi;
		ascii_t base;
	} span_t;

	localparam cp_t IDEO_SPACE   = 21'h03000;
	localparam cp_t WIDTH_SHIFT  = 21'h0FEE0;
	localparam cp_t MATH_DIG_LO  = 21'h1D7CE;
	localparam cp_t MATH_DIG_HI  = 21'h1D7FF;

	localparam int N_LIKE   = 25;
	localparam int N_RUNS   = 26;
	localparam int N_HOLED  = 5;
	localparam int N_HOLES  = 18;
	localparam int N_DRUNS  = 12;
	localparam int N_DSING  = 33;

	localparam pair_t LETTERLIKE [N_LIKE] = '{
		'{21'h2102, 7'h43}, '{21'h210A, 7'h67}, '{21'h210B, 7'h48}, '{21'h210C, 7'h48},
		'{21'h210D, 7'h48}, '{21'h2110, 7'h49}, '{21'h2111, 7'h49}, '{21'h2112, 7'h4C},
		'{21'h2113, 7'h6C}, '{21'h2115, 7'h4E}, '{21'h2119, 7'h50}, '{21'h211A, 7'h51},
		'{21'h211B, 7'h52}, '{21'h211C, 7'h52}, '{21'h211D, 7'h52}, '{21'h2124, 7'h5A},
		'{21'h2128, 7'h5A}, '{21'h212A, 7'h4B}, '{21'h212C, 7'h42}, '{21'h212D, 7'h43},
		'{21'h212F, 7'h65}, '{21'h2130, 7'h45}, '{21'h2131, 7'h46}, '{21'h2133, 7'h4D},
		'{21'h2134, 7'h6F}
	};

	// 26-letter ranges without holes: start and first letter
	localparam pair_t LETTER_RUNS [N_RUNS] = '{
		'{21'h0FF21, 7'h41}, '{21'h0FF41, 7'h61}, '{21'h0249C, 7'h61}, '{21'h024B6, 7'h41},
		'{21'h024D0, 7'h61}, '{21'h1D400, 7'h41}, '{21'h1D41A, 7'h61}, '{21'h1D44E, 7'h61},
		'{21'h1D468, 7'h41}, '{21'h1D482, 7'h61}, '{21'h1D4D0, 7'h41}, '{21'h1D4EA, 7'h61},
		'{21'h1D51E, 7'h61}, '{21'h1D56C, 7'h41}, '{21'h1D586, 7'h61}, '{21'h1D552, 7'h61},
		'{21'h1D5A0, 7'h41}, '{21'h1D5BA, 7'h61}, '{21'h1D5D4, 7'h41}, '{21'h1D5EE, 7'h61},
		'{21'h1D608, 7'h41}, '{21'h1D622, 7'h61}, '{21'h1D63C, 7'h41}, '{21'h1D656, 7'h61},
		'{21'h1D670, 7'h41}, '{21'h1D68A, 7'h61}
	};

	localparam span_t HOLED_RUNS [N_HOLED] = '{
		'{21'h1D434, 21'h1D44D, 7'h41}, '{21'h1D49C, 21'h1D4B5, 7'h41},
		'{21'h1D4B6, 21'h1D4CF, 7'h61}, '{21'h1D504, 21'h1D51C, 7'h41},
		'{21'h1D538, 21'h1D54F, 7'h41}
	};

	localparam cp_t HOLES [N_HOLES] = '{
		21'h1D439,
		21'h1D49D, 21'h1D4A0, 21'h1D4A1, 21'h1D4A3, 21'h1D4A4, 21'h1D4A7, 21'h1D4A8,
		21'h1D4AD,
		21'h1D4BA, 21'h1D4BC,
		21'h1D506,
		21'h1D53A, 21'h1D53F, 21'h1D545, 21'h1D547, 21'h1D548, 21'h1D549
	};

	localparam span_t DIGIT_RUNS [N_DRUNS] = '{
		'{21'h0FF10, 21'h0FF19, 7'h30}, '{21'h02074, 21'h02079, 7'h34},
		'{21'h02080, 21'h02089, 7'h30}, '{21'h02460, 21'h02468, 7'h31},
		'{21'h02474, 21'h0247C, 7'h31}, '{21'h02488, 21'h02490, 7'h31},
		'{21'h024F5, 21'h024FD, 7'h31}, '{21'h02780, 21'h02788, 7'h31},
		'{21'h0278A, 21'h02792, 7'h31}, '{21'h03220, 21'h03228, 7'h31},
		'{21'h03280, 21'h03288, 7'h31}, '{21'h03021, 21'h03029, 7'h31}
	};

	localparam pair_t DIGIT_SINGLES [N_DSING] = '{
		'{21'h2070, 7'h30}, '{21'h00B9, 7'h31}, '{21'h00B2, 7'h32}, '{21'h00B3, 7'h33},
		'{21'h24EA, 7'h30}, '{21'h24FF, 7'h30},
		'{21'h96F6, 7'h30}, '{21'h3007, 7'h30}, '{21'h25CB, 7'h30}, '{21'h25EF, 7'h30},
		'{21'h4E00, 7'h31}, '{21'h58F9, 7'h31},
		'{21'h4E8C, 7'h32}, '{21'h4E24, 7'h32}, '{21'h5169, 7'h32}, '{21'h8D30, 7'h32},
		'{21'h8CB3, 7'h32},
		'{21'h4E09, 7'h33}, '{21'h53C1, 7'h33}, '{21'h53C3, 7'h33},
		'{21'h56DB, 7'h34}, '{21'h8086, 7'h34},
		'{21'h4E94, 7'h35}, '{21'h4F0D, 7'h35},
		'{21'h516D, 7'h36}, '{21'h9646, 7'h36}, '{21'h9678, 7'h36},
		'{21'h4E03, 7'h37}, '{21'h67D2, 7'h37},
		'{21'h516B, 7'h38}, '{21'h634C, 7'h38},
		'{21'h4E5D, 7'h39}, '{21'h7396, 7'h39}
	};

	function automatic cp_t to_cp(ascii_t a);
		return {{(CP_W-7){1'b0}}, a};
	endfunction

	// fullwidth space and punctuation to ascii
	function automatic cp_t fold_fullwidth(cp_t c);
		cp_t r;
		r = c;
		if (c == IDEO_SPACE)
			r = 21'h00020;
		else if ((c >= 21'h0FF01 && c <= 21'h0FF0F) || (c >= 21'h0FF1A && c <= 21'h0FF20) ||
		         (c >= 21'h0FF3B && c <= 21'h0FF40) || (c >= 21'h0FF5B && c <= 21'h0FF5E))
			r = c - WIDTH_SHIFT;
		return r;
	endfunction

	// later assignments win: holed runs, then plain runs, then letterlike
	function automatic cp_t fold_letters(cp_t c);
		cp_t        r;
		cp_t        d;
		logic [3:0] below;
		logic       hole;
		r = c;
		for (int i = N_HOLED - 1; i >= 0; i--) begin
			if (c >= HOLED_RUNS[i].lo && c <= HOLED_RUNS[i].hi) begin
				d     = c - HOLED_RUNS[i].lo;
				below = '0;
				hole  = 1'b0;
				for (int k = 0; k < N_HOLES; k++) begin
					if (HOLES[k] >= HOLED_RUNS[i].lo && HOLES[k] <= HOLED_RUNS[i].hi) begin
						if (HOLES[k] == c)
							hole = 1'b1;
						if (HOLES[k] < c)
							below = below + 4'd1;
					end
				end
				if (hole)
					r = c;
				else
					r = to_cp(HOLED_RUNS[i].base + {2'b00, d[4:0]} - {3'b000, below});
			end
		end
		for (int i = N_RUNS - 1; i >= 0; i--) begin
			if (c >= LETTER_RUNS[i].cp && c <= CP_W'(LETTER_RUNS[i].cp + 21'd25)) begin
				d = c - LETTER_RUNS[i].cp;
				r = to_cp(LETTER_RUNS[i].to + {2'b00, d[4:0]});
			end
		end
		for (int i = N_LIKE - 1; i >= 0; i--) begin
			if (c == LETTERLIKE[i].cp)
				r = to_cp(LETTERLIKE[i].to);
		end
		return r;
	endfunction

	// later assignments win: singles, then math digits, then digit runs
	function automatic cp_t fold_digits(cp_t c);
		cp_t         r;
		cp_t         d;
		logic [5:0]  off;
		logic [10:0] prod;
		logic [2:0]  quo;
		logic [5:0]  rem;
		r    = c;
		d    = c - MATH_DIG_LO;
		off  = d[5:0];
		// off / 10 via multiply by 13 and shift, exact for off below 69
		prod = {5'b00000, off} * 11'd13;
		quo  = prod[9:7];
		rem  = off - 6'({quo, 3'b000} + {2'b00, quo, 1'b0});
		for (int i = N_DSING - 1; i >= 0; i--) begin
			if (c == DIGIT_SINGLES[i].cp)
				r = to_cp(DIGIT_SINGLES[i].to);
		end
		if (c >= MATH_DIG_LO && c <= MATH_DIG_HI)
			r = to_cp(7'h30 + {3'b000, rem[3:0]});
		for (int i = N_DRUNS - 1; i >= 0; i--) begin
			if (c >= DIGIT_RUNS[i].lo && c <= DIGIT_RUNS[i].hi) begin
				d = c - DIGIT_RUNS[i].lo;
				r = to_cp(DIGIT_RUNS[i].base + {3'b000, d[3:0]});
			end
		end
		return r;
	endfunction

	function automatic cp_t fold_case(cp_t c);
		cp_t r;
		r = c;
		if (c >= 21'h00041 && c <= 21'h0005A)
			r = c + 21'h00020;
		return r;
	endfunction

endpackage

### rtl/core/code_point_style_folder.sv
// ----------------------------------------------------------------------------
// code_point_style_folder
// Folds one code point per transfer through width, letter-style, digit-style
// and case stages, each enabled by its own configuration bit.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  -------   ---------  -----------------  ---------------------------------
//  s_*       in         s_tvalid/s_tready  s_tdata[20:0] code_point_in
//  m_*       out        m_tvalid/m_tready  m_tdata[20:0] code_point_out
//  cfg_*     in         cfg_we             cfg_index, cfg_wdata[0]
//
//  path from input transfer to result transfer: an input register, then the
//  four fold stages as one combinational path into the output register; one
//  transfer per cycle is sustained while m_tready stays high
//  arst_n clears the valid bits and all four enables
//  a stalled output holds its result while the input register keeps taking
//  one more transfer, so back pressure reaches s_tready only when both are full
//
module code_point_style_folder
	import cpsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [20:0] code_point_in, [23:21] unused
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [20:0] code_point_out, [23:21] zero
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [0:0]         cfg_wdata
);

	// configuration enables
	logic fold_width_q;
	logic fold_letter_q;
	logic fold_digit_q;
	logic fold_case_q;

	// pipeline registers
	logic v_s1;
	cp_t  cp_s1;
	logic v_s2;
	cp_t  cp_s2;

	logic adv_s2;
	logic adv_s1;
	cp_t  c_width;
	cp_t  c_letter;
	cp_t  c_digit;
	cp_t  c_case;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_width_q  <= 1'b0;
			fold_letter_q <= 1'b0;
			fold_digit_q  <= 1'b0;
			fold_case_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOLD_WIDTH:  fold_width_q  <= cfg_wdata[0];
				REG_FOLD_LETTER: fold_letter_q <= cfg_wdata[0];
				REG_FOLD_DIGIT:  fold_digit_q  <= cfg_wdata[0];
				REG_FOLD_CASE:   fold_case_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// output register moves when empty or drained; input register feeds it
	assign adv_s2   = !v_s2 || m_tready;
	assign adv_s1   = s_tvalid && s_tready;
	assign s_tready = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			cp_s1 <= s_tdata[CP_W-1:0];
		if (adv_s2 && v_s1)
			cp_s2 <= c_case;
	end

	// fold chain, each stage sees the previous stage's result
	always_comb begin
		c_width  = fold_width_q  ? fold_fullwidth(cp_s1) : cp_s1;
		c_letter = fold_letter_q ? fold_letters(c_width) : c_width;
		c_digit  = fold_digit_q  ? fold_digits(c_letter) : c_letter;
		c_case   = fold_case_q   ? fold_case(c_digit)    : c_digit;
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {{(TDATA_W-CP_W){1'b0}}, cp_s2};

endmodule

### rtl/core/cpsf_checker.sv
// ----------------------------------------------------------------------------
// cpsf_checker
// Port-level checks for the code point folder, bound to the top level.
// ----------------------------------------------------------------------------
module cpsf_checker
	import cpsf_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [TDATA_W-1:0] s_tdata,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               cfg_we,
	input logic [IDX_W-1:0]   cfg_index,
	input logic [0:0]         cfg_wdata
);

	// a stalled result stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// a draining output never blocks the input side
	a_ready_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output drains");

	// padding bits of a result are zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:CP_W] == '0)
		else $error("result padding not zero");

	// input taken while no result is shown reaches m_tvalid via both registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid && m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing after two cycles");

endmodule

bind code_point_style_folder cpsf_checker u_cpsf_checker (.*);

### tb/sv/code_point_style_folder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_point_style_folder_checker
// Watches the input, output and register-write ports of the code point
// folder. It keeps its own copy of the four fold enables, works out the
// folded code point for every input transfer, and compares each output
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module code_point_style_folder_checker
	import cpsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [20:0] code_point_in
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,   // [20:0] code_point_out
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [0:0]         cfg_wdata,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic case_on;
		logic digit_on;
		logic letter_on;
		logic width_on;
	} fold_modes_t;

	localparam int unsigned ASC_UP_A = 'h41;
	localparam int unsigned ASC_LO_A = 'h61;
	localparam int unsigned ASC_ZERO = 'h30;

	localparam int unsigned LIKE_CP [25] = '{
		'h2102, 'h210A, 'h210B, 'h210C, 'h210D, 'h2110, 'h2111, 'h2112, 'h2113,
		'h2115, 'h2119, 'h211A, 'h211B, 'h211C, 'h211D, 'h2124, 'h2128, 'h212A,
		'h212C, 'h212D, 'h212F, 'h2130, 'h2131, 'h2133, 'h2134
	};
	localparam int unsigned LIKE_TO [25] = '{
		'h43, 'h67, 'h48, 'h48, 'h48, 'h49, 'h49, 'h4C, 'h6C,
		'h4E, 'h50, 'h51, 'h52, 'h52, 'h52, 'h5A, 'h5A, 'h4B,
		'h42, 'h43, 'h65, 'h45, 'h46, 'h4D, 'h6F
	};

	// 26 letters each, no holes
	localparam int unsigned RUN_START [26] = '{
		'hFF21, 'hFF41, 'h249C, 'h24B6, 'h24D0, 'h1D400, 'h1D41A, 'h1D44E, 'h1D468,
		'h1D482, 'h1D4D0, 'h1D4EA, 'h1D51E, 'h1D56C, 'h1D586, 'h1D552, 'h1D5A0,
		'h1D5BA, 'h1D5D4, 'h1D5EE, 'h1D608, 'h1D622, 'h1D63C, 'h1D656, 'h1D670,
		'h1D68A
	};
	localparam int unsigned RUN_FIRST [26] = '{
		'h41, 'h61, 'h61, 'h41, 'h61, 'h41, 'h61, 'h61, 'h41,
		'h61, 'h41, 'h61, 'h61, 'h41, 'h61, 'h61, 'h41,
		'h61, 'h41, 'h61, 'h41, 'h61, 'h41, 'h61, 'h41,
		'h61
	};

	localparam int unsigned GAPPED_LO [5]   = '{'h1D434, 'h1D49C, 'h1D4B6, 'h1D504, 'h1D538};
	localparam int unsigned GAPPED_HI [5]   = '{'h1D44D, 'h1D4B5, 'h1D4CF, 'h1D51C, 'h1D54F};
	localparam int unsigned GAPPED_BASE [5] = '{'h41, 'h41, 'h61, 'h41, 'h41};

	localparam int unsigned RESERVED_CP [18] = '{
		'h1D439, 'h1D49D, 'h1D4A0, 'h1D4A1, 'h1D4A3, 'h1D4A4, 'h1D4A7, 'h1D4A8,
		'h1D4AD, 'h1D4BA, 'h1D4BC, 'h1D506, 'h1D53A, 'h1D53F, 'h1D545, 'h1D547,
		'h1D548, 'h1D549
	};

	localparam int unsigned DIGRUN_LO [12] = '{
		'hFF10, 'h2074, 'h2080, 'h2460, 'h2474, 'h2488,
		'h24F5, 'h2780, 'h278A, 'h3220, 'h3280, 'h3021
	};
	localparam int unsigned DIGRUN_HI [12] = '{
		'hFF19, 'h2079, 'h2089, 'h2468, 'h247C, 'h2490,
		'h24FD, 'h2788, 'h2792, 'h3228, 'h3288, 'h3029
	};
	localparam int unsigned DIGRUN_BASE [12] = '{
		'h30, 'h34, 'h30, 'h31, 'h31, 'h31, 'h31, 'h31, 'h31, 'h31, 'h31, 'h31
	};

	localparam int unsigned NUMERAL_CP [33] = '{
		'h2070, 'h00B9, 'h00B2, 'h00B3, 'h24EA, 'h24FF, 'h96F6, 'h3007, 'h25CB,
		'h25EF, 'h4E00, 'h58F9, 'h4E8C, 'h4E24, 'h5169, 'h8D30, 'h8CB3, 'h4E09,
		'h53C1, 'h53C3, 'h56DB, 'h8086, 'h4E94, 'h4F0D, 'h516D, 'h9646, 'h9678,
		'h4E03, 'h67D2, 'h516B, 'h634C, 'h4E5D, 'h7396
	};
	localparam int unsigned NUMERAL_TO [33] = '{
		'h30, 'h31, 'h32, 'h33, 'h30, 'h30, 'h30, 'h30, 'h30,
		'h30, 'h31, 'h31, 'h32, 'h32, 'h32, 'h32, 'h32, 'h33,
		'h33, 'h33, 'h34, 'h34, 'h35, 'h35, 'h36, 'h36, 'h36,
		'h37, 'h37, 'h38, 'h38, 'h39, 'h39
	};

	function automatic int unsigned width_fold(int unsigned c);
		if (c == IDEO_SPACE)
			return 'h20;
		if ((c >= 'hFF01 && c <= 'hFF0F) || (c >= 'hFF1A && c <= 'hFF20) ||
		    (c >= 'hFF3B && c <= 'hFF40) || (c >= 'hFF5B && c <= 'hFF5E))
			return c - WIDTH_SHIFT;
		return c;
	endfunction

	function automatic int unsigned letter_fold(int unsigned c);
		int unsigned skipped;
		for (int i = 0; i < 25; i++)
			if (LIKE_CP[i] == c)
				return LIKE_TO[i];
		for (int i = 0; i < 26; i++)
			if (c >= RUN_START[i] && c <= RUN_START[i] + 25)
				return RUN_FIRST[i] + (c - RUN_START[i]);
		for (int i = 0; i < 5; i++) begin
			if (c >= GAPPED_LO[i] && c <= GAPPED_HI[i]) begin
				skipped = 0;
				for (int k = 0; k < 18; k++) begin
					if (RESERVED_CP[k] < GAPPED_LO[i] || RESERVED_CP[k] > GAPPED_HI[i])
						continue;
					if (RESERVED_CP[k] == c)
						return c;
					if (RESERVED_CP[k] < c)
						skipped++;
				end
				return GAPPED_BASE[i] + (c - GAPPED_LO[i]) - skipped;
			end
		end
		return c;
	endfunction

	function automatic int unsigned digit_fold(int unsigned c);
		for (int i = 0; i < 12; i++)
			if (c >= DIGRUN_LO[i] && c <= DIGRUN_HI[i])
				return DIGRUN_BASE[i] + (c - DIGRUN_LO[i]);
		if (c >= MATH_DIG_LO && c <= MATH_DIG_HI)
			return ASC_ZERO + (c - MATH_DIG_LO) % 10;
		for (int i = 0; i < 33; i++)
			if (NUMERAL_CP[i] == c)
				return NUMERAL_TO[i];
		return c;
	endfunction

	function automatic int unsigned case_fold(int unsigned c);
		if (c >= ASC_UP_A && c <= ASC_UP_A + 25)
			return c + (ASC_LO_A - ASC_UP_A);
		return c;
	endfunction

	function automatic cp_t fold_code_point(cp_t c, fold_modes_t m);
		int unsigned v;
		v = c;
		if (m.width_on)
			v = width_fold(v);
		if (m.letter_on)
			v = letter_fold(v);
		if (m.digit_on)
			v = digit_fold(v);
		if (m.case_on)
			v = case_fold(v);
		return cp_t'(v);
	endfunction

	fold_modes_t modes;
	cp_t         folded_q [$];

	// outputs are retired before the same edge's input is queued
	always @(posedge clk or negedge arst_n) begin
		cp_t got;
		cp_t want;
		if (!arst_n) begin
			modes = '0;
			folded_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[CP_W-1:0];
				if (folded_q.size() == 0) begin
					$error("code_point_out: expected none, actual %h", got);
					errors++;
				end else begin
					want = folded_q.pop_front();
					if (got !== want) begin
						$error("code_point_out: expected %h, actual %h", want, got);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				folded_q = {folded_q, fold_code_point(s_tdata[CP_W-1:0], modes)};
			if (cfg_we) begin
				case (cfg_index)
					REG_FOLD_WIDTH:  modes.width_on  = cfg_wdata[0];
					REG_FOLD_LETTER: modes.letter_on = cfg_wdata[0];
					REG_FOLD_DIGIT:  modes.digit_on  = cfg_wdata[0];
					REG_FOLD_CASE:   modes.case_on   = cfg_wdata[0];
					default: ;
				endcase
			end
		end
		pending = folded_q.size();
	end

endmodule

### tb/sv/code_point_style_folder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_point_style_folder_tb
// Drives code points into the folder under a series of fold-enable settings:
// a directed set of range edges, reserved holes and out-of-range values, then
// random code points weighted toward the styled ranges. Both stream sides
// idle in random bursts; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module code_point_style_folder_tb;
	import cpsf_pkg::*;

	localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer before giving up
	localparam int N_PHASES     = 8;
	localparam int PHASE_ITEMS  = 80;
	localparam int SETTLE_TICKS = 3;      // input register plus output register, with margin

	// enable sets per random phase: [0] width, [1] letter, [2] digit, [3] case
	localparam logic [3:0] PHASE_MODES [N_PHASES] = '{
		4'b0000, 4'b1111, 4'b0001, 4'b0010, 4'b0100, 4'b1000, 4'b0110, 4'b1011
	};

	// holes, range ends, numerals and out-of-range values
	localparam cp_t ODD_POINTS [32] = '{
		21'h1D439, 21'h1D49D, 21'h1D4A0, 21'h1D4AD, 21'h1D4BA, 21'h1D4BC, 21'h1D506,
		21'h1D53A, 21'h1D549, 21'h1D54A, 21'h1D51C, 21'h1D51D, 21'h1D54F, 21'h1D550,
		21'h03007, 21'h04E00, 21'h096F6, 21'h07396, 21'h08D30, 21'h000B9, 21'h02070,
		21'h024EA, 21'h024FF, 21'h03000, 21'h10FFFF, 21'h110000, 21'h1FFFFF, 21'h0212F,
		21'h02113, 21'h02134, 21'h1D7FF, 21'h1D800
	};

	localparam cp_t EDGE_POINTS [25] = '{
		21'h03000, 21'h0FF01, 21'h0FF5E, 21'h0FF21, 21'h0FF5A, 21'h1D439, 21'h1D43A,
		21'h1D4AE, 21'h1D51C, 21'h1D54F, 21'h02102, 21'h02134, 21'h1D7CE, 21'h1D7FF,
		21'h02074, 21'h04E00, 21'h07396, 21'h00041, 21'h0005A, 21'h1FFFFF, 21'h110000,
		21'h00000, 21'h10FFFF, 21'h0249C, 21'h1D586
	};

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata   = '0;     // [20:0] code_point_in, [23:21] zero
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;            // [20:0] code_point_out, [23:21] zero
	logic               cfg_we    = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [0:0]         cfg_wdata = '0;

	int errors;
	int pending;
	bit idle_on;            // random idling on both sides while set
	int hold_left;          // remaining sink stall cycles
	int quiet_ticks;
	int sent_count;
	int checked_count;
	int setting_count;

	always #5 clk = ~clk;

	code_point_style_folder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	code_point_style_folder_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	// sink side: stalls come in bursts of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			hold_left = $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog and transfer counts
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				checked_count++;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_ticks = 0;
			else
				quiet_ticks++;
			if (quiet_ticks >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results outstanding",
				         QUIET_LIMIT, pending);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// one input transfer, with an optional gap in front of it; valid stays
	// high afterwards so back-to-back transfers need no extra edge
	task automatic send_code_point(input cp_t c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(c);
		do
			@(posedge clk);
		while (!s_tready);
		sent_count++;
	endtask

	// hold input until every result is back, then let the pipe settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic load_modes(input logic [3:0] m);
		write_reg(REG_FOLD_WIDTH,  m[0]);
		write_reg(REG_FOLD_LETTER, m[1]);
		write_reg(REG_FOLD_DIGIT,  m[2]);
		write_reg(REG_FOLD_CASE,   m[3]);
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	// mostly styled ranges; full 21-bit values make every bit toggle
	function automatic cp_t pick_code_point();
		case ($urandom_range(0, 9))
			0:       return cp_t'($urandom);
			1:       return cp_t'($urandom_range(0, 'h7F));
			2:       return cp_t'($urandom_range('hFF00, 'hFF6F));
			3:       return cp_t'($urandom_range('h2070, 'h2140));
			4:       return cp_t'($urandom_range('h2450, 'h2800));
			5:       return cp_t'($urandom_range('h1D400, 'h1D6A3));
			6:       return cp_t'($urandom_range('h1D7C0, 'h1D805));
			7:       return cp_t'($urandom_range('h3000, 'h3290));
			8:       return ODD_POINTS[$urandom_range(0, 31)];
			default: return cp_t'($urandom_range(0, 'hFFFF));
		endcase
	endfunction

	initial begin
		logic [3:0] m;
		idle_on = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every stage on, range edges and holes
		load_modes(4'b1111);
		foreach (EDGE_POINTS[i])
			send_code_point(EDGE_POINTS[i]);
		drain_results();

		// random phases; the last one runs with no idling at all
		for (int p = 0; p < N_PHASES; p++) begin
			m = PHASE_MODES[p];
			if (p == N_PHASES - 2)
				m = 4'($urandom);
			load_modes(m);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// each phase opens with a stretch free of idling
				idle_on = (p != N_PHASES - 1) && (k >= 16);
				send_code_point(pick_code_point());
			end
			idle_on = 1'b0;
			drain_results();
		end

		repeat (SETTLE_TICKS) @(posedge clk);
		$display("covered %0d code points under %0d enable settings, %0d results compared",
		         sent_count, setting_count, checked_count);
		$display("input paused until empty before every setting change");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
rtl/core/cpsf_pkg.sv
rtl/core/code_point_style_folder.sv
rtl/core/cpsf_checker.sv
tb/sv/code_point_style_folder_checker.sv
tb/sv/code_point_style_folder_tb.sv
